>>> hdl/grain128_reduced_round_keystream_unit_assert.svh
// assertion macros for the grain-128 keystream unit
`ifndef GRAIN128_REDUCED_ROUND_KEYSTREAM_UNIT_ASSERT_SVH
`define GRAIN128_REDUCED_ROUND_KEYSTREAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("grain128 same-cycle check failed");
// next-cycle implication
`define GR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("grain128 next-cycle check failed");
`else
`define GR_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define GR_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> hdl/gr128_pkg.sv
// shared types and constants for the grain-128 keystream unit
`timescale 1ns / 1ps
package gr128_pkg;

  localparam int KEY_BITS        = 128;
  localparam int IV_BITS         = 96;
  localparam int INIT_CLOCKS_DEF = 256;
  localparam int CELL_BITS       = 8;
  localparam int NUM_CELLS       = KEY_BITS / CELL_BITS;
  localparam int ROUNDS_W        = 4;
  localparam int ROUNDS_FULL     = 13;
  localparam int CFG_DATA_W      = 64;
  localparam int IV_HIGH_W       = IV_BITS - 64;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_KEY_LOW  = 3'd0,
    REG_KEY_HIGH = 3'd1,
    REG_IV_LOW   = 3'd2,
    REG_IV_HIGH  = 3'd3,
    REG_ROUNDS   = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_INIT = 1'b1
  } state_t;

  // per-cycle command to every cell of the register row
  typedef struct packed {
    logic load;
    logic shift8;
    logic shift1;
  } cell_ctrl_t;

endpackage

>>> hdl/gr128_cell.sv
// one byte slice of the nonlinear and linear registers
`timescale 1ns / 1ps
module gr128_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gr128_pkg::cell_ctrl_t          ctrl,
  input  logic [gr128_pkg::CELL_BITS-1:0] ld_b,
  input  logic [gr128_pkg::CELL_BITS-1:0] ld_s,
  input  logic [gr128_pkg::CELL_BITS-1:0] nb_in,
  input  logic [gr128_pkg::CELL_BITS-1:0] sb_in,
  output logic [gr128_pkg::CELL_BITS-1:0] b_q,
  output logic [gr128_pkg::CELL_BITS-1:0] s_q
);
  import gr128_pkg::*;

  logic [CELL_BITS-1:0] b_r, b_nxt;
  logic [CELL_BITS-1:0] s_r, s_nxt;

  always_comb begin
    b_nxt = b_r;
    s_nxt = s_r;
    if (ctrl.load) begin
      b_nxt = ld_b;
      s_nxt = ld_s;
    end else if (ctrl.shift8) begin
      b_nxt = nb_in;
      s_nxt = sb_in;
    end else if (ctrl.shift1) begin
      b_nxt = {nb_in[0], b_r[CELL_BITS-1:1]};
      s_nxt = {sb_in[0], s_r[CELL_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
      s_r <= '0;
    end else begin
      b_r <= b_nxt;
      s_r <= s_nxt;
    end
  end

  assign b_q = b_r;
  assign s_q = s_r;

endmodule

>>> hdl/gr128_fb.sv
// eight unrolled cipher clocks: feedback bits and keystream bits
`timescale 1ns / 1ps
module gr128_fb (
  input  logic [gr128_pkg::KEY_BITS-1:0]  b,
  input  logic [gr128_pkg::KEY_BITS-1:0]  s,
  input  logic [gr128_pkg::ROUNDS_W-1:0]  rounds,
  input  logic                            feed,
  output logic [gr128_pkg::CELL_BITS-1:0] nb,
  output logic [gr128_pkg::CELL_BITS-1:0] lb,
  output logic [gr128_pkg::CELL_BITS-1:0] z
);
  import gr128_pkg::*;

  logic [ROUNDS_FULL:1] en;

  // a term of level l is active once rounds exceeds l-1
  always_comb begin
    en[1] = 1'b1;
    for (int l = 2; l <= ROUNDS_FULL; l++) begin
      en[l] = (rounds > ROUNDS_W'(l - 1));
    end
  end

  // step k sees the register shifted by k; highest tap is 96+7, below any new bit
  always_comb begin
    for (int k = 0; k < CELL_BITS; k++) begin
      z[k] = b[2+k]
           ^ (en[2] & b[15+k]) ^ (en[3] & b[36+k]) ^ (en[4] & b[45+k])
           ^ (en[5] & b[64+k]) ^ (en[6] & b[73+k]) ^ (en[7] & b[89+k])
           ^ (en[8] & s[93+k])
           ^ (en[9] & b[12+k] & s[8+k])
           ^ (en[10] & s[13+k] & s[20+k])
           ^ (en[11] & b[95+k] & s[42+k])
           ^ (en[12] & s[60+k] & s[79+k])
           ^ (en[13] & b[12+k] & b[95+k] & s[95+k]);
      nb[k] = s[k]
            ^ (en[2] & b[k]) ^ (en[3] & b[26+k]) ^ (en[4] & b[56+k])
            ^ (en[5] & b[91+k]) ^ (en[6] & b[96+k])
            ^ (en[7] & b[3+k] & b[67+k])
            ^ (en[8] & b[11+k] & b[13+k])
            ^ (en[9] & b[17+k] & b[18+k])
            ^ (en[10] & b[27+k] & b[59+k])
            ^ (en[11] & b[40+k] & b[48+k])
            ^ (en[12] & b[61+k] & b[65+k])
            ^ (en[13] & b[68+k] & b[84+k])
            ^ (feed & z[k]);
      lb[k] = s[k]
            ^ (en[3] & s[7+k]) ^ (en[5] & s[38+k]) ^ (en[7] & s[70+k])
            ^ (en[11] & s[81+k]) ^ (en[13] & s[96+k])
            ^ (feed & z[k]);
    end
  end

endmodule

>>> hdl/grain128_reduced_round_keystream_unit.sv
// grain-128 keystream unit with selectable term count
// data beat: result registered, offered next cycle; one byte per cycle unless stalled
// start beat: loads key and iv, then busy running INIT_CLOCKS cipher clocks with feedback,
//   eight per cycle through the feedback unit, single clocks for the tail
// reset (rst_n low, synchronous): registers but out_byte cleared, rounds set to 13, idle
`timescale 1ns / 1ps
`include "grain128_reduced_round_keystream_unit_assert.svh"
module grain128_reduced_round_keystream_unit #(
  parameter int INIT_CLOCKS = gr128_pkg::INIT_CLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic [7:0]                         in_data_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  // configuration write port
  input  logic                               cfg_we,
  input  gr128_pkg::cfg_idx_t                cfg_index,
  input  logic [gr128_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gr128_pkg::*;

  // remaining cipher clocks of the initialization run
  localparam int CNT_W = (INIT_CLOCKS > 0) ? $clog2(INIT_CLOCKS + 1) : 1;
  localparam int CMP_W = CNT_W + 4;

  // configuration registers
  logic [63:0]          key_low_r, key_high_r, iv_low_r;
  logic [IV_HIGH_W-1:0] iv_high_r;
  logic [ROUNDS_W-1:0]  rounds_r;

  // control
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] remaining_r, remaining_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;

  cell_ctrl_t ctrl;
  logic       feed;
  logic       in_fire;
  logic       out_free;
  logic       big_step;

  // full register images gathered from the cell row
  logic [KEY_BITS-1:0] b_all, s_all, ld_b_all, ld_s_all;
  logic [CELL_BITS-1:0] fb_nb, fb_lb, fb_z;

  assign in_fire  = in_valid && in_ready;
  // output slot is free, or is being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  assign big_step = ({4'b0, remaining_r} >= CMP_W'(CELL_BITS));

  // key into the nonlinear register, iv plus all-ones padding into the linear one
  assign ld_b_all = {key_high_r, key_low_r};
  assign ld_s_all = {{(KEY_BITS - IV_BITS){1'b1}}, iv_high_r, iv_low_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      iv_low_r   <= '0;
      iv_high_r  <= '0;
      rounds_r   <= ROUNDS_W'(ROUNDS_FULL);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_IV_LOW:   iv_low_r   <= cfg_data;
        REG_IV_HIGH:  iv_high_r  <= cfg_data[IV_HIGH_W-1:0];
        REG_ROUNDS:   rounds_r   <= cfg_data[ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (cmd_t'(in_command) == CMD_START) && (INIT_CLOCKS > 0)) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (remaining_nxt == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    ctrl     = '0;
    feed     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          if (cmd_t'(in_command) == CMD_START) begin
            ctrl.load = 1'b1;
          end else begin
            ctrl.shift8 = 1'b1;
          end
        end
      end
      ST_INIT: begin
        // output bit fed back into both registers during initialization
        feed        = 1'b1;
        ctrl.shift8 = big_step;
        ctrl.shift1 = !big_step;
      end
      default: ;
    endcase
  end

  // init clock counter: eight per cycle, single clocks for the tail
  always_comb begin
    remaining_nxt = remaining_r;
    if (ctrl.load) begin
      remaining_nxt = CNT_W'(INIT_CLOCKS);
    end else if (state_r == ST_INIT) begin
      remaining_nxt = big_step ? (remaining_r - CNT_W'(CELL_BITS))
                               : (remaining_r - CNT_W'(1));
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && (cmd_t'(in_command) == CMD_DATA)) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = in_data_byte ^ fb_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // one byte of feedback and keystream bits from the current register image
  gr128_fb u_fb (
    .b      (b_all),
    .s      (s_all),
    .rounds (rounds_r),
    .feed   (feed),
    .nb     (fb_nb),
    .lb     (fb_lb),
    .z      (fb_z)
  );

  // row of byte cells; each takes its upper neighbor's byte, the top one the new bits
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [CELL_BITS-1:0] nb_up, sb_up;
    if (i == NUM_CELLS - 1) begin : g_top
      assign nb_up = fb_nb;
      assign sb_up = fb_lb;
    end else begin : g_mid
      assign nb_up = b_all[(i+1)*CELL_BITS +: CELL_BITS];
      assign sb_up = s_all[(i+1)*CELL_BITS +: CELL_BITS];
    end
    gr128_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .ld_b  (ld_b_all[i*CELL_BITS +: CELL_BITS]),
      .ld_s  (ld_s_all[i*CELL_BITS +: CELL_BITS]),
      .nb_in (nb_up),
      .sb_in (sb_up),
      .b_q   (b_all[i*CELL_BITS +: CELL_BITS]),
      .s_q   (s_all[i*CELL_BITS +: CELL_BITS])
    );
  end

  // checks
  `GR_ASSERT_SAME(a_busy_no_ready, clk, rst_n, state_r == ST_INIT, !in_ready)
  `GR_ASSERT_SAME(a_init_count_live, clk, rst_n, state_r == ST_INIT, remaining_r != '0)
  `GR_ASSERT_NEXT(a_data_gives_beat, clk, rst_n, in_fire && in_command == CMD_DATA, out_valid_r)
  `GR_ASSERT_SAME(a_one_cell_op, clk, rst_n, 1'b1, $onehot0({ctrl.load, ctrl.shift8, ctrl.shift1}))

endmodule

>>> verif/grain128_keystream_checker.sv
// keystream predictor and result checker for the grain-128 keystream unit
`timescale 1ns / 1ps
module grain128_keystream_checker #(
  parameter int INIT_CLOCKS = gr128_pkg::INIT_CLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_command,
  input  logic [7:0]                       in_data_byte,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [7:0]                       out_byte,
  input  logic                             cfg_we,
  input  gr128_pkg::cfg_idx_t              cfg_index,
  input  logic [gr128_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatch_count,
  output int                               results_pending
);
  import gr128_pkg::*;

  // mirrored settings
  logic [63:0]          key_lo, key_hi, iv_lo;
  logic [IV_HIGH_W-1:0] iv_hi;
  logic [ROUNDS_W-1:0]  term_count;

  // predicted cipher state, bit 0 leaves first
  logic [KEY_BITS-1:0] nfsr, lfsr;

  logic [7:0] expected_bytes[$];

  // one cipher clock, returns the keystream bit
  function automatic logic grain_clock(input logic feed);
    logic [KEY_BITS-1:0] b, s;
    logic z, nb, lb;
    b  = nfsr;
    s  = lfsr;
    z  = b[2];
    nb = s[0];
    lb = s[0];
    if (term_count > 1) begin
      z  = z ^ b[15];
      nb = nb ^ b[0];
    end
    if (term_count > 2) begin
      z  = z ^ b[36];
      nb = nb ^ b[26];
      lb = lb ^ s[7];
    end
    if (term_count > 3) begin
      z  = z ^ b[45];
      nb = nb ^ b[56];
    end
    if (term_count > 4) begin
      z  = z ^ b[64];
      nb = nb ^ b[91];
      lb = lb ^ s[38];
    end
    if (term_count > 5) begin
      z  = z ^ b[73];
      nb = nb ^ b[96];
    end
    if (term_count > 6) begin
      z  = z ^ b[89];
      nb = nb ^ (b[3] & b[67]);
      lb = lb ^ s[70];
    end
    if (term_count > 7) begin
      z  = z ^ s[93];
      nb = nb ^ (b[11] & b[13]);
    end
    if (term_count > 8) begin
      z  = z ^ (b[12] & s[8]);
      nb = nb ^ (b[17] & b[18]);
    end
    if (term_count > 9) begin
      z  = z ^ (s[13] & s[20]);
      nb = nb ^ (b[27] & b[59]);
    end
    if (term_count > 10) begin
      z  = z ^ (b[95] & s[42]);
      nb = nb ^ (b[40] & b[48]);
      lb = lb ^ s[81];
    end
    if (term_count > 11) begin
      z  = z ^ (s[60] & s[79]);
      nb = nb ^ (b[61] & b[65]);
    end
    if (term_count > 12) begin
      z  = z ^ (b[12] & b[95] & s[95]);
      nb = nb ^ (b[68] & b[84]);
      lb = lb ^ s[96];
    end
    if (feed) begin
      nb = nb ^ z;
      lb = lb ^ z;
    end
    nfsr = {nb, b[KEY_BITS-1:1]};
    lfsr = {lb, s[KEY_BITS-1:1]};
    return z;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic [7:0] ks;
    if (!rst_n) begin
      key_lo     = '0;
      key_hi     = '0;
      iv_lo      = '0;
      iv_hi      = '0;
      term_count = ROUNDS_W'(ROUNDS_FULL);
      nfsr       = '0;
      lfsr       = '0;
      expected_bytes.delete();
      mismatch_count  = 0;
      results_pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LOW:  key_lo = cfg_data;
          REG_KEY_HIGH: key_hi = cfg_data;
          REG_IV_LOW:   iv_lo = cfg_data;
          REG_IV_HIGH:  iv_hi = cfg_data[IV_HIGH_W-1:0];
          REG_ROUNDS:   term_count = cfg_data[ROUNDS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_START) begin
          nfsr = {key_hi, key_lo};
          lfsr = {{(KEY_BITS - IV_BITS){1'b1}}, iv_hi, iv_lo};
          for (int n = 0; n < INIT_CLOCKS; n++) void'(grain_clock(1'b1));
        end else begin
          for (int k = 0; k < 8; k++) ks[k] = grain_clock(1'b0);
          expected_bytes.push_back(in_data_byte ^ ks);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected out_byte", out_byte, 8'h00);
        end else begin
          if (out_byte !== expected_bytes[0])
            report_mismatch("out_byte", out_byte, expected_bytes[0]);
          void'(expected_bytes.pop_front());
        end
      end
      results_pending = expected_bytes.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// top-level testbench for the grain-128 keystream unit: stimulus, flow control, verdict
`timescale 1ns / 1ps
module tb_top;
  import gr128_pkg::*;

  localparam int RANDOM_BEATS   = 1620;
  // settle wait after a start beat: covers its busy time, plus margin
  localparam int SETTLE_CYCLES  = INIT_CLOCKS_DEF / 8 + 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 600000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_command;
  logic [7:0]            in_data_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int results_pending;
  int beats_sent = 0;
  int cycle_count = 0;

  // flow-control knobs: calm_tx for the sender, calm_rx and rx_hold_req for the receiver
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;
  bit rx_hold_req = 1'b0;

  always #10 clk = ~clk;

  grain128_reduced_round_keystream_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  grain128_keystream_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random hold-off per result beat, optional long stall to back up the pipe
  initial begin
    int unsigned hold;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req) begin
        hold = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        hold = calm_rx ? 0 : $urandom_range(0, 12);
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one input beat; valid stays up across back-to-back beats
  task automatic send_beat(input logic cmd, input logic [7:0] data);
    int unsigned gap;
    gap = calm_tx ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // drain everything, let a trailing start finish, then rewrite all settings
  task automatic program_cipher(input logic [63:0] klo, input logic [63:0] khi,
                                input logic [63:0] ivlo, input logic [63:0] ivhi,
                                input logic [63:0] rnd);
    in_valid <= 1'b0;
    wait (results_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_KEY_LOW, klo);
    write_reg(REG_KEY_HIGH, khi);
    write_reg(REG_IV_LOW, ivlo);
    write_reg(REG_IV_HIGH, ivhi);
    write_reg(REG_ROUNDS, rnd);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // term count: mostly legal, with the extremes and the out-of-range codes mixed in
  function automatic logic [63:0] pick_rounds();
    logic [63:0] upper;
    upper = ($urandom_range(0, 3) == 0) ? rand64() : 64'd0;
    case ($urandom_range(0, 7))
      0:       return {upper[63:4], 4'd1};
      1:       return {upper[63:4], 4'(ROUNDS_FULL)};
      2:       return {upper[63:4], 4'($urandom_range(0, 15))};
      default: return {upper[63:4], 4'($urandom_range(1, 13))};
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0, 1:    return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    int phase;
    int beats_in_phase;
    in_valid     <= 1'b0;
    in_command   <= CMD_DATA;
    in_data_byte <= 8'h00;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_KEY_LOW;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data before any start runs from the all-zero registers
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'hFF);
    // start with reset settings: zero key and iv, full term count
    send_beat(CMD_START, 8'hFF);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'hA5);
    // all-ones key and iv; upper bits of iv_high and rounds words must be dropped
    program_cipher('1, '1, '1, '1, {60'hFFF_FFFF_FFFF_FFFF, 4'd13});
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_DATA, 8'h00);
    send_beat(CMD_DATA, 8'hFF);
    // single-term functions
    program_cipher('0, '0, '0, '0, 64'd1);
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_DATA, 8'h5A);
    send_beat(CMD_DATA, 8'h00);
    // term count zero acts as one
    program_cipher(rand64(), rand64(), rand64(), rand64(), 64'd0);
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_DATA, 8'h3C);
    // fourteen and fifteen act as the full cipher
    program_cipher(rand64(), rand64(), rand64(), rand64(), 64'd14);
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_DATA, 8'hC3);
    program_cipher(rand64(), rand64(), rand64(), rand64(), '1);
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_DATA, 8'h80);
    send_beat(CMD_DATA, 8'h01);
    // new term count without a restart changes the running keystream
    program_cipher(rand64(), rand64(), rand64(), rand64(), 64'd7);
    send_beat(CMD_DATA, 8'h7E);

    // random phases: mostly start followed by a data run, some runs continue
    // the previous stream under new settings, occasional restarts mid-run
    phase = 0;
    while (beats_sent < RANDOM_BEATS) begin
      calm_tx = ($urandom_range(0, 4) == 0);
      calm_rx = ($urandom_range(0, 4) == 0);
      if (phase == 2) begin
        // long receiver stall while the sender keeps pushing: the unit backs up
        program_cipher(rand64(), rand64(), rand64(), rand64(), 64'd13);
        calm_tx = 1'b1;
        calm_rx = 1'b0;
        send_beat(CMD_START, 8'h00);
        rx_hold_req = 1'b1;
        beats_in_phase = 80;
      end else begin
        if ($urandom_range(0, 7) != 0)
          program_cipher(rand64(), rand64(), rand64(), rand64(), pick_rounds());
        else
          in_valid <= 1'b0;
        if ($urandom_range(0, 7) != 0) send_beat(CMD_START, 8'($urandom()));
        beats_in_phase = (phase % 10 == 9) ? $urandom_range(100, 160)
                                           : $urandom_range(10, 50);
      end
      for (int i = 0; i < beats_in_phase; i++) begin
        if (phase != 2 && $urandom_range(0, 15) == 0)
          send_beat(CMD_START, 8'($urandom()));
        else
          send_beat(CMD_DATA, pick_byte());
      end
      phase++;
    end

    // drain, then give any stray result time to show up
    in_valid <= 1'b0;
    calm_rx = 1'b1;
    wait (results_pending == 0);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
